// ----- design/ota_pkg.sv -----
// ----------------------------------------------------------------------------
// ota_pkg: shared types and constants for overlap track association.
// Holds table sizes, box layout and the sequencer state type.
// ----------------------------------------------------------------------------
package ota_pkg;

    localparam int MAX_TRACKS = 64;
    localparam int COORD_BITS = 12;
    localparam int SIZE_BITS  = COORD_BITS + 1;
    localparam int IDX_BITS   = $clog2(MAX_TRACKS);
    localparam int CNT_BITS   = $clog2(MAX_TRACKS + 1);
    localparam int EDGE_BITS  = COORD_BITS + 2;
    localparam int AREA_BITS  = 2 * SIZE_BITS;
    localparam int FRAC_BITS  = 9;
    localparam int PROD_BITS  = AREA_BITS + FRAC_BITS;
    localparam int OUT_IDX_BITS = 6;
    localparam logic [FRAC_BITS-1:0] FRAC_RESET = 9'd128;
    localparam int REG_MATCH_FRACTION = 0;

    typedef struct packed {
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [SIZE_BITS-1:0]  width;
        logic [SIZE_BITS-1:0]  height;
    } box_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EDGE,
        ST_MULT,
        ST_SCALE,
        ST_CMP,
        ST_DONE
    } state_t;

endpackage

// ----- design/ota_box_compare.sv -----
// ----------------------------------------------------------------------------
// ota_box_compare: pipelined overlap test of two boxes.
// Three register stages: the overlap extent, the areas, then the scaled compare.
// ----------------------------------------------------------------------------
module ota_box_compare (
    input  logic                          clk,
    input  ota_pkg::box_t                 box_a,
    input  ota_pkg::box_t                 box_b,
    input  logic [ota_pkg::FRAC_BITS-1:0] fraction,
    output logic                          match
);
    import ota_pkg::*;

    logic [EDGE_BITS-1:0] ra, rb, ba, bb, x1, y1, x0, y0;
    logic [SIZE_BITS-1:0] dx_next, dy_next, dx_reg, dy_reg;
    logic [SIZE_BITS-1:0] wa_reg, ha_reg, wb_reg, hb_reg;
    logic [AREA_BITS-1:0] ov_reg, aa_reg, ab_reg;
    logic [PROD_BITS-1:0] ov_s, pa, pb;
    logic [FRAC_BITS-1:0] frac_reg;
    logic [FRAC_BITS-1:0] frac2_reg;

    // Stage one: intersection extent with the smaller right and bottom edge.
    always_comb
    begin
        ra = EDGE_BITS'(box_a.left) + EDGE_BITS'(box_a.width);
        rb = EDGE_BITS'(box_b.left) + EDGE_BITS'(box_b.width);
        ba = EDGE_BITS'(box_a.top) + EDGE_BITS'(box_a.height);
        bb = EDGE_BITS'(box_b.top) + EDGE_BITS'(box_b.height);
        x1 = (ra < rb) ? ra : rb;
        y1 = (ba < bb) ? ba : bb;
        x0 = (box_a.left > box_b.left) ? EDGE_BITS'(box_a.left) : EDGE_BITS'(box_b.left);
        y0 = (box_a.top > box_b.top) ? EDGE_BITS'(box_a.top) : EDGE_BITS'(box_b.top);
        dx_next = (x1 > x0) ? SIZE_BITS'(x1 - x0) : '0;
        dy_next = (y1 > y0) ? SIZE_BITS'(y1 - y0) : '0;
    end

    always_ff @(posedge clk)
    begin
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        wa_reg   <= box_a.width;
        ha_reg   <= box_a.height;
        wb_reg   <= box_b.width;
        hb_reg   <= box_b.height;
        frac_reg <= fraction;
        // Stage two: the three areas.
        ov_reg <= AREA_BITS'(dx_reg) * AREA_BITS'(dy_reg);
        aa_reg <= AREA_BITS'(wa_reg) * AREA_BITS'(ha_reg);
        ab_reg <= AREA_BITS'(wb_reg) * AREA_BITS'(hb_reg);
    end

    // Stage three: scale the areas by the fraction and compare.
    always_ff @(posedge clk)
    begin
        frac2_reg <= frac_reg;
    end

    always_comb
    begin
        ov_s = PROD_BITS'(ov_reg) << 8;
        pa   = PROD_BITS'(aa_reg) * PROD_BITS'(frac2_reg);
        pb   = PROD_BITS'(ab_reg) * PROD_BITS'(frac2_reg);
    end

    always_ff @(posedge clk)
    begin
        match <= (ov_s > pa) || (ov_s > pb);
    end

endmodule

// ----- design/overlap_track_association_top.sv -----
// Overlap track association top level.
// Tracks are scanned in order from zero until the first match or the last stored track.
// A new box is accepted only when idle and after the previous result has been taken.
// Each track takes a table read, three compare stages and a decision.
// Reset: asynchronous, clears the track count and sets match_fraction to 128.
// ----------------------------------------------------------------------------
// overlap_track_association_top: box-to-track association engine.
// Scans a box table held in a synchronous memory and updates it in place.
// The box table has no reset; only entries below the track count are compared.
// ----------------------------------------------------------------------------
module overlap_track_association_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [1:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [ota_pkg::COORD_BITS-1:0]     box_left,
    input  logic [ota_pkg::COORD_BITS-1:0]     box_top,
    input  logic [ota_pkg::SIZE_BITS-1:0]      box_width,
    input  logic [ota_pkg::SIZE_BITS-1:0]      box_height,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [ota_pkg::OUT_IDX_BITS-1:0]   track_index,
    output logic                               started_new,
    output logic                               table_full
);
    import ota_pkg::*;

    logic [FRAC_BITS-1:0] frac_reg;
    logic [CNT_BITS-1:0]  used_reg, used_next;
    logic [IDX_BITS-1:0]  scan_reg, scan_next;
    box_t                 box_reg;
    box_t                 mem_rd_reg;
    box_t                 mem [MAX_TRACKS];
    state_t               state_reg, state_next;
    logic                 match;
    logic                 mem_we;
    logic [IDX_BITS-1:0]  mem_wa;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_IDX_BITS-1:0] idx_reg, idx_next;
    logic                 new_reg, new_next, full_reg, full_next;
    logic                 last_scan;

    assign pready = 1'b1;
    assign prdata = 32'(frac_reg);

    // Configuration register write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frac_reg <= FRAC_RESET;
        else if (psel && penable && pwrite && paddr == 2'(REG_MATCH_FRACTION * 4))
            frac_reg <= pwdata[FRAC_BITS-1:0];
    end

    // Box table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= box_reg;
        mem_rd_reg <= mem[scan_reg];
    end

    ota_box_compare u_cmp (
        .clk      (clk),
        .box_a    (box_reg),
        .box_b    (mem_rd_reg),
        .fraction (frac_reg),
        .match    (match)
    );

    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign track_index = idx_reg;
    assign started_new = new_reg;
    assign table_full  = full_reg;
    assign last_scan = (CNT_BITS'(scan_reg) + 1'b1) >= used_reg;

    // Input capture.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            box_reg <= '{left: box_left, top: box_top, width: box_width, height: box_height};
    end

    // Next-state logic of the scan sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_valid && in_ready)
                          state_next = (used_reg == '0) ? ST_DONE : ST_READ;
            ST_READ:  state_next = ST_EDGE;
            ST_EDGE:  state_next = ST_MULT;
            ST_MULT:  state_next = ST_SCALE;
            ST_SCALE: state_next = ST_CMP;
            ST_CMP:
            begin
                if (match)
                    state_next = ST_IDLE;
                else if (last_scan)
                    state_next = ST_DONE;
                else
                    state_next = ST_READ;
            end
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Output and datapath control of the sequencer.
    always_comb
    begin
        scan_next      = scan_reg;
        used_next      = used_reg;
        out_valid_next = out_valid_reg && !out_ready;
        idx_next       = idx_reg;
        new_next       = new_reg;
        full_next      = full_reg;
        mem_we         = 1'b0;
        mem_wa         = scan_reg;
        case (state_reg)
            ST_IDLE: scan_next = '0;
            ST_CMP:
            begin
                if (match)
                begin
                    mem_we         = 1'b1;
                    idx_next       = OUT_IDX_BITS'(scan_reg);
                    new_next       = 1'b0;
                    full_next      = 1'b0;
                    out_valid_next = 1'b1;
                end
                else if (!last_scan)
                    scan_next = scan_reg + 1'b1;
            end
            ST_DONE:
            begin
                out_valid_next = 1'b1;
                if (used_reg >= CNT_BITS'(MAX_TRACKS))
                begin
                    idx_next  = '0;
                    new_next  = 1'b0;
                    full_next = 1'b1;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_wa    = used_reg[IDX_BITS-1:0];
                    idx_next  = OUT_IDX_BITS'(used_reg);
                    new_next  = 1'b1;
                    full_next = 1'b0;
                    used_next = used_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        new_reg  <= new_next;
        full_reg <= full_next;
    end

endmodule

// ----- test/ota_scoreboard.sv -----
// ----------------------------------------------------------------------------
// ota_scoreboard: track association predictor and result checker.
// Keeps its own track table and threshold, predicts one result per box and
// compares results against the oldest pending prediction.
// ----------------------------------------------------------------------------
package ota_scoreboard_pkg;

    import ota_pkg::*;

    typedef struct {
        logic [OUT_IDX_BITS-1:0] index;
        logic                    opened;
        logic                    full;
    } assoc_t;

    class track_scoreboard;
        box_t                    track_box[MAX_TRACKS];
        int unsigned             track_count;
        logic [FRAC_BITS-1:0]    fraction;
        assoc_t                  pending[$];
        int unsigned             mismatches;
        int unsigned             checked;
        int unsigned             opened_seen;
        int unsigned             full_seen;
        int unsigned             matched_seen;

        function new();
            track_count = 0;
            fraction    = FRAC_RESET;
            mismatches  = 0;
            checked     = 0;
            opened_seen = 0;
            full_seen   = 0;
            matched_seen = 0;
        endfunction

        // True intersection area of two boxes, zero when they do not meet.
        function longint unsigned overlap(box_t a, box_t b);
            longint unsigned x0, x1, y0, y1, ra, rb, ba, bb;
            ra = longint'(a.left) + a.width;
            rb = longint'(b.left) + b.width;
            ba = longint'(a.top) + a.height;
            bb = longint'(b.top) + b.height;
            x0 = (a.left > b.left) ? a.left : b.left;
            x1 = (ra < rb) ? ra : rb;
            y0 = (a.top > b.top) ? a.top : b.top;
            y1 = (ba < bb) ? ba : bb;
            if (x1 <= x0 || y1 <= y0)
                return 0;
            return (x1 - x0) * (y1 - y0);
        endfunction

        function bit same_object(box_t a, box_t b);
            longint unsigned ov, aa, ab;
            ov = overlap(a, b) * 256;
            aa = longint'(a.width) * a.height * fraction;
            ab = longint'(b.width) * b.height * fraction;
            return (ov > aa) || (ov > ab);
        endfunction

        // Predict the association for an accepted box request.
        function void note_box(box_t b);
            assoc_t r;
            r.index = '0; r.opened = 0; r.full = 0;
            for (int i = 0; i < track_count; i++)
            begin
                if (same_object(b, track_box[i]))
                begin
                    track_box[i] = b;
                    r.index = i[OUT_IDX_BITS-1:0];
                    pending.insert(pending.size(), r);
                    return;
                end
            end
            if (track_count >= MAX_TRACKS)
                r.full = 1;
            else
            begin
                track_box[track_count] = b;
                r.index  = track_count[OUT_IDX_BITS-1:0];
                r.opened = 1;
                track_count++;
            end
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(logic [OUT_IDX_BITS-1:0] idx, logic opened,
                                   logic full);
            assoc_t e;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: index %0d new %0b full %0b",
                             idx, opened, full);
                return;
            end
            e = pending[0];
            pending.delete(0);
            if (e.opened) opened_seen++;
            else if (e.full) full_seen++;
            else matched_seen++;
            if (idx !== e.index || opened !== e.opened || full !== e.full)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected index %0d new %0b full %0b, got %0d %0b %0b",
                             e.index, e.opened, e.full, idx, opened, full);
            end
        endfunction
    endclass

endpackage

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: overlap track association regression.
// Programs the match threshold over several phases, sends directed and random
// boxes with random idling on both channels and checks every result.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import ota_pkg::*;
    import ota_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic                    clk;
    logic                    rst_n;
    logic                    psel, penable, pwrite;
    logic [1:0]              paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;
    logic                    in_valid, in_ready;
    logic [COORD_BITS-1:0]   box_left, box_top;
    logic [SIZE_BITS-1:0]    box_width, box_height;
    logic                    out_valid, out_ready;
    logic [OUT_IDX_BITS-1:0] track_index;
    logic                    started_new, table_full;

    track_scoreboard sb;
    bit              quiet_tail;
    int unsigned     cycles;
    int unsigned     boxes_sent;

    overlap_track_association_top dut (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Cycle counter with a hard limit on the run.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles", cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Result side: random stalls, check every accepted result.
    initial
    begin
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet_tail && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 0;
                repeat ($urandom_range(1, 16)) @(negedge clk);
            end
            out_ready <= 1;
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result(track_index, started_new, table_full);
        end
    end

    task automatic write_fraction(logic [FRAC_BITS-1:0] value);
        @(negedge clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= 2'(REG_MATCH_FRACTION * 4); pwdata <= 32'(value);
        @(negedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.fraction = value;
        @(negedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // Drain all predictions, then allow the worst-case scan latency.
    task automatic wait_idle();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (5 * MAX_TRACKS + 10) @(posedge clk);
    endtask

    task automatic send_box(int unsigned l, int unsigned t, int unsigned w,
                            int unsigned h);
        box_t b;
        @(negedge clk);
        if (!quiet_tail && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        b.left = l[COORD_BITS-1:0]; b.top = t[COORD_BITS-1:0];
        b.width = w[SIZE_BITS-1:0]; b.height = h[SIZE_BITS-1:0];
        in_valid <= 1;
        box_left <= b.left; box_top <= b.top;
        box_width <= b.width; box_height <= b.height;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_box(b);
        boxes_sent++;
        @(negedge clk);
        in_valid <= 0;
    endtask

    // Random box: mostly near a stored track so matches happen, rarely huge.
    task automatic random_box();
        int unsigned l, t, w, h, k;
        if (sb.track_count != 0 && $urandom_range(0, 2) != 0)
        begin
            k = $urandom_range(0, sb.track_count - 1);
            l = (sb.track_box[k].left + $urandom_range(0, 8)) % 4096;
            t = (sb.track_box[k].top + $urandom_range(0, 8)) % 4096;
            w = sb.track_box[k].width;
            h = sb.track_box[k].height;
            if (w == 0) w = 1;
            if (h == 0) h = 1;
        end
        else
        begin
            l = $urandom_range(0, 4095);
            t = $urandom_range(0, 4095);
            if ($urandom_range(0, 19) == 0)
            begin
                w = $urandom_range(1, 4096);
                h = $urandom_range(1, 4096);
            end
            else
            begin
                w = $urandom_range(1, 64);
                h = $urandom_range(1, 64);
            end
        end
        send_box(l, t, w, h);
    endtask

    initial
    begin
        logic [FRAC_BITS-1:0] fracs[6];
        sb = new();
        quiet_tail = 0;
        boxes_sent = 0;
        rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        in_valid = 0;
        box_left = '0; box_top = '0; box_width = '0; box_height = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed part at the reset threshold: extremes and containment.
        send_box(0, 0, 4096, 4096);
        send_box(4095, 4095, 1, 1);
        send_box(100, 100, 10, 10);
        send_box(102, 102, 4, 4);
        send_box(4095, 0, 4096, 1);
        send_box(0, 4095, 1, 4096);
        send_box(0, 0, 0, 5);
        send_box(0, 0, 5, 0);
        send_box(2048, 2048, 8191, 8191);
        wait_idle();

        // Fraction zero: any positive overlap matches.
        write_fraction(9'd0);
        send_box(101, 101, 2, 2);
        send_box(4000, 4000, 95, 95);
        wait_idle();

        // Fraction above 256 and the field maximum: nothing ever matches,
        // which also fills the table.
        write_fraction(9'd257);
        for (int i = 0; i < 30; i++)
            send_box(100, 100, 10, 10);
        wait_idle();
        write_fraction(9'd511);
        for (int i = 0; i < 30; i++)
            send_box(100, 100, 10, 10);
        wait_idle();

        // Random phases at several thresholds; the table fills early, so
        // reset is not repeated and later phases exercise the full table.
        fracs = '{9'd256, 9'd1, 9'd64, 9'd200, 9'd128, 9'd32};
        for (int p = 0; p < 6; p++)
        begin
            write_fraction(fracs[p]);
            for (int i = 0; i < 110; i++)
            begin
                if (p == 5 && i > 70) quiet_tail = 1;
                random_box();
            end
            // Hold off the sender until every result is in.
            wait_idle();
        end
        write_fraction(9'($urandom_range(0, 511)));
        for (int i = 0; i < 30; i++)
            random_box();
        wait_idle();

        $display("Sent %0d boxes: %0d matched, %0d opened, %0d on a full table",
                 boxes_sent, sb.matched_seen, sb.opened_seen, sb.full_seen);
        $display("Checked %0d results, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- overlap_track_association_top.f -----
design/ota_pkg.sv
design/ota_box_compare.sv
design/overlap_track_association_top.sv
test/ota_scoreboard.sv
test/testbench.sv
